>>> hw/rtl/assert_macros.svh
// assert_macros.svh: assertion macros shared by the RTL modules.
// Expects clk_i and rst_ni in the scope of every use.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every clock edge outside reset.
`define ASSERT_HOLDS(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// When pre holds, post must hold in the next cycle.
`define ASSERT_NEXT(label, pre, post, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) else $error(msg);

`endif

>>> hw/rtl/isl_pkg.sv
// isl_pkg: types and constants of the interval stopwatch logger.
// No dependencies.
package isl_pkg;

  // Request codes
  typedef enum logic [2:0] {
    REQ_START      = 3'd0,
    REQ_STOP       = 3'd1,
    REQ_RESTART    = 3'd2,
    REQ_CLEAR      = 3'd3,
    REQ_GET_COUNT  = 3'd4,
    REQ_GET_VALUES = 3'd5
  } req_e;

  // Sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DECODE,
    ST_MUL,
    ST_DIV,
    ST_EMIT,
    ST_FETCH
  } state_e;

  // Configuration register indexes
  localparam int  CFG_IDX_W  = 1;
  localparam logic [CFG_IDX_W-1:0] CFG_TICKS  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_OUT_EN = 1'b1;

  localparam logic [31:0] TICKS_RESET = 32'd32768;

  // Microseconds per second, fits in 20 bits
  localparam int          MICROS_W       = 20;
  localparam logic [MICROS_W-1:0] MICROS_PER_SEC = 20'd1000000;
  localparam int          PROD_W         = 32 + MICROS_W;

  // Cap on results of one get-values request
  localparam int MAX_RESULTS = 32;

  typedef struct packed {
    logic [2:0]  req_type;
    logic [2:0]  slot;
    logic [31:0] tag;
    logic [31:0] now_stamp;
  } req_item_t;

  typedef struct packed {
    logic        status;
    logic        wrapped;
    logic [4:0]  log_count_out;
    logic        entry_valid;
    logic [31:0] entry_tag;
    logic [31:0] entry_micros;
    logic        last;
    logic [7:0]  pin_levels;
  } res_item_t;

  // Divider status towards the sequencer
  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

>>> hw/rtl/isl_chan_if.sv
// isl_chan_if: valid/ready channels for request and result items.
// Depends on isl_pkg.
interface isl_req_if;
  logic               valid;
  logic               ready;
  isl_pkg::req_item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface isl_res_if;
  logic               valid;
  logic               ready;
  isl_pkg::res_item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

>>> hw/rtl/interval_stopwatch_logger.sv
// interval_stopwatch_logger: stopwatch slots with a wrapping log of timed, tagged items.
// Depends on isl_pkg, isl_chan_if, isl_ram, isl_mdiv and assert_macros.svh.
//
//   channel   dir   kind               payload
//   req_ch    in    valid/ready item   req_type, slot, tag, now_stamp
//   res_ch    out   valid/ready item   status .. pin_levels (isl_pkg::res_item_t)
//   cfg_*     in    write only         cfg_idx_i selects register, cfg_data_i value
//
// Start, clear, get-count and unknown requests: DECODE, then EMIT to the output register.
// Stop and restart on a running slot go through MUL and DIV, waiting on the shared
// divider which makes one quotient bit a cycle over the 52-bit scaled product.
// Get-values: after DECODE, one result per logged entry each cycle the sink is ready.
// One item at a time; req_ch is ready only while the sequencer idles, which it
// may do with the last result still waiting in the output register.
// Reset clears slot state and the log count; log contents are not cleared.
`include "assert_macros.svh"

module interval_stopwatch_logger #(
  parameter int SLOT_COUNT = 8,
  parameter int LOG_DEPTH  = 32
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [isl_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [31:0]                     cfg_data_i,
  isl_req_if.sink                         req_ch,
  isl_res_if.source                       res_ch
);
  localparam int SLOT_AW = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
  localparam int LOG_AW  = $clog2(LOG_DEPTH);

  // Configuration
  logic [31:0] tps_q;
  logic        oe_q;

  // Sequencer and slot state
  isl_pkg::state_e     state_q, state_d;
  logic [SLOT_COUNT-1:0] running_q, running_d;
  logic [LOG_AW-1:0]   cnt_q, cnt_d;
  logic [LOG_AW-1:0]   idx_q, idx_d;
  logic                status_q, status_d;
  logic                wrap_q, wrap_d;
  logic                ev_q, ev_d;

  // Latched request and working data
  isl_pkg::req_e       req_q, req_d;
  logic [2:0]          slot_q, slot_d;
  logic [31:0]         tag_q, tag_d;
  logic [31:0]         now_q, now_d;
  logic [31:0]         elapsed_q, elapsed_d;
  logic [31:0]         mic_q, mic_d;

  // Output register
  logic                out_valid_q, out_valid_d;
  isl_pkg::res_item_t  out_data_q, out_next;
  logic                out_load, out_free;

  // Memory and divider hookup
  logic                stamp_we, stamp_re;
  logic [31:0]         stamp_rdata;
  logic                log_we, log_re;
  logic [LOG_AW-1:0]   log_raddr;
  logic [63:0]         log_rdata;
  logic                div_start;
  logic [31:0]         quot;
  isl_pkg::div_stat_t  div_stat;

  logic                do_start;
  logic                slot_ok;
  logic [SLOT_AW-1:0]  slot_idx;
  logic                last_entry;
  logic [7:0]          pins;

  assign slot_ok  = 7'(slot_q) < 7'(SLOT_COUNT);
  assign slot_idx = SLOT_AW'(slot_q);
  assign out_free = !out_valid_q || res_ch.ready;

  // Final entry of a log dump: end of the log or the result cap
  assign last_entry = (idx_q == LOG_AW'(cnt_q - 1'b1)) ||
                      (7'(idx_q) == 7'(isl_pkg::MAX_RESULTS - 1));

  // Pins mirror running slots 0..7
  for (genvar k = 0; k < 8; k++) begin : g_pin
    if (k < SLOT_COUNT) begin : g_live
      assign pins[k] = running_q[k];
    end else begin : g_none
      assign pins[k] = 1'b0;
    end
  end

  isl_ram #(
    .WIDTH (32),
    .DEPTH (SLOT_COUNT)
  ) u_stamp_ram (
    .clk_i   (clk_i),
    .we_i    (stamp_we),
    .waddr_i (slot_idx),
    .wdata_i (now_q),
    .re_i    (stamp_re),
    .raddr_i (SLOT_AW'(req_ch.data.slot)),
    .rdata_o (stamp_rdata)
  );

  isl_ram #(
    .WIDTH (64),
    .DEPTH (LOG_DEPTH)
  ) u_log_ram (
    .clk_i   (clk_i),
    .we_i    (log_we),
    .waddr_i (cnt_q),
    .wdata_i ({tag_q, quot}),
    .re_i    (log_re),
    .raddr_i (log_raddr),
    .rdata_o (log_rdata)
  );

  isl_mdiv u_mdiv (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (div_start),
    .elapsed_i (elapsed_q),
    .divisor_i (tps_q),
    .quot_o    (quot),
    .stat_o    (div_stat)
  );

  // Sequencer
  always_comb begin
    state_d   = state_q;
    running_d = running_q;
    cnt_d     = cnt_q;
    idx_d     = idx_q;
    status_d  = status_q;
    wrap_d    = wrap_q;
    ev_d      = ev_q;
    req_d     = req_q;
    slot_d    = slot_q;
    tag_d     = tag_q;
    now_d     = now_q;
    elapsed_d = elapsed_q;
    mic_d     = mic_q;
    stamp_we  = 1'b0;
    stamp_re  = 1'b0;
    log_we    = 1'b0;
    log_re    = 1'b0;
    log_raddr = LOG_AW'(idx_q + 1'b1);
    div_start = 1'b0;
    out_load  = 1'b0;
    out_next  = '0;
    do_start  = 1'b0;
    req_ch.ready = 1'b0;

    unique case (state_q)
      isl_pkg::ST_IDLE: begin
        req_ch.ready = 1'b1;
        if (req_ch.valid) begin
          req_d    = isl_pkg::req_e'(req_ch.data.req_type);
          slot_d   = req_ch.data.slot;
          tag_d    = req_ch.data.tag;
          now_d    = req_ch.data.now_stamp;
          stamp_re = 1'b1;  // stamp ready in DECODE
          state_d  = isl_pkg::ST_DECODE;
        end
      end

      isl_pkg::ST_DECODE: begin
        status_d = 1'b0;
        wrap_d   = 1'b0;
        ev_d     = 1'b0;
        state_d  = isl_pkg::ST_EMIT;
        unique case (req_q)
          isl_pkg::REQ_START: do_start = 1'b1;
          isl_pkg::REQ_STOP,
          isl_pkg::REQ_RESTART: begin
            if (slot_ok && running_q[slot_idx]) begin
              elapsed_d = now_q - stamp_rdata;
              state_d   = isl_pkg::ST_MUL;
            end else begin
              status_d = 1'b1;
              do_start = (req_q == isl_pkg::REQ_RESTART);
            end
          end
          isl_pkg::REQ_CLEAR: cnt_d = '0;
          isl_pkg::REQ_GET_VALUES: begin
            if (cnt_q != '0) begin
              idx_d     = '0;
              log_re    = 1'b1;
              log_raddr = '0;
              state_d   = isl_pkg::ST_FETCH;
            end
          end
          default: ;  // get-count and unknown codes: plain acknowledgment
        endcase
      end

      isl_pkg::ST_MUL: begin
        div_start = 1'b1;
        state_d   = isl_pkg::ST_DIV;
      end

      isl_pkg::ST_DIV: begin
        if (div_stat.done) begin
          log_we              = 1'b1;
          wrap_d              = (cnt_q == LOG_AW'(LOG_DEPTH - 1));
          cnt_d               = wrap_d ? '0 : LOG_AW'(cnt_q + 1'b1);
          running_d[slot_idx] = 1'b0;
          mic_d               = quot;
          ev_d                = 1'b1;
          do_start            = (req_q == isl_pkg::REQ_RESTART);
          state_d             = isl_pkg::ST_EMIT;
        end
      end

      isl_pkg::ST_EMIT: begin
        if (out_free) begin
          out_load               = 1'b1;
          out_next.status        = status_q;
          out_next.wrapped       = wrap_q;
          out_next.log_count_out = 5'(cnt_q);
          out_next.entry_valid   = ev_q;
          out_next.entry_tag     = ev_q ? tag_q : '0;
          out_next.entry_micros  = ev_q ? mic_q : '0;
          out_next.last          = 1'b1;
          out_next.pin_levels    = oe_q ? pins : '0;
          state_d                = isl_pkg::ST_IDLE;
        end
      end

      isl_pkg::ST_FETCH: begin
        // log_rdata holds entry idx_q; next read is issued as this one leaves
        if (out_free) begin
          out_load               = 1'b1;
          out_next.log_count_out = 5'(cnt_q);
          out_next.entry_valid   = 1'b1;
          out_next.entry_tag     = log_rdata[63:32];
          out_next.entry_micros  = log_rdata[31:0];
          out_next.last          = last_entry;
          out_next.pin_levels    = oe_q ? pins : '0;
          if (last_entry) begin
            state_d = isl_pkg::ST_IDLE;
          end else begin
            idx_d  = LOG_AW'(idx_q + 1'b1);
            log_re = 1'b1;
          end
        end
      end

      default: state_d = isl_pkg::ST_IDLE;
    endcase

    // Start half: arm the slot, a zero stamp leaves it idle
    if (do_start && slot_ok) begin
      stamp_we            = 1'b1;
      running_d[slot_idx] = (now_q != '0);
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (res_ch.ready) begin
      out_valid_d = 1'b0;
    end
  end

  assign res_ch.valid = out_valid_q;
  assign res_ch.data  = out_data_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= isl_pkg::ST_IDLE;
      running_q   <= '0;
      cnt_q       <= '0;
      idx_q       <= '0;
      status_q    <= 1'b0;
      wrap_q      <= 1'b0;
      ev_q        <= 1'b0;
      req_q       <= isl_pkg::REQ_START;
      out_valid_q <= 1'b0;
      tps_q       <= isl_pkg::TICKS_RESET;
      oe_q        <= 1'b0;
    end else begin
      state_q     <= state_d;
      running_q   <= running_d;
      cnt_q       <= cnt_d;
      idx_q       <= idx_d;
      status_q    <= status_d;
      wrap_q      <= wrap_d;
      ev_q        <= ev_d;
      req_q       <= req_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        if (cfg_idx_i == isl_pkg::CFG_TICKS) begin
          tps_q <= cfg_data_i;
        end else if (cfg_idx_i == isl_pkg::CFG_OUT_EN) begin
          oe_q <= cfg_data_i[0];
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    slot_q    <= slot_d;
    tag_q     <= tag_d;
    now_q     <= now_d;
    elapsed_q <= elapsed_d;
    mic_q     <= mic_d;
    if (out_load) begin
      out_data_q <= out_next;
    end
  end

  `ASSERT_HOLDS(a_done_in_div, div_stat.done |-> state_q == isl_pkg::ST_DIV, "divider done outside wait state")
  `ASSERT_HOLDS(a_cnt_range, 32'(cnt_q) < 32'(LOG_DEPTH), "log count beyond log depth")
  `ASSERT_HOLDS(a_entry_status, res_ch.valid && res_ch.data.entry_valid |-> !res_ch.data.status, "entry with idle status")
  `ASSERT_NEXT(a_stop_clears, state_q == isl_pkg::ST_DIV && div_stat.done && req_q == isl_pkg::REQ_STOP, !running_q[slot_idx], "stopped slot still running")
  `ASSERT_HOLDS(a_load_free, out_load |-> out_free, "result overwritten before taken")
endmodule

>>> hw/rtl/isl_ram.sv
// isl_ram: generic single-write, single-read RAM with registered read data.
// No dependencies.
module isl_ram #(
  parameter  int WIDTH = 32,
  parameter  int DEPTH = 8,
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic                   clk_i,
  input  logic                   we_i,
  input  logic [AW-1:0]          waddr_i,
  input  logic [WIDTH-1:0]       wdata_i,
  input  logic                   re_i,
  input  logic [AW-1:0]          raddr_i,
  output logic [WIDTH-1:0]       rdata_o
);
  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;
endmodule

>>> hw/rtl/isl_mdiv.sv
// isl_mdiv: scales elapsed ticks to microseconds, (elapsed * 1e6) / divisor.
// One registered multiply, then a restoring divider, one quotient bit a cycle.
// Depends on isl_pkg and assert_macros.svh.
`include "assert_macros.svh"

module isl_mdiv (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  input  logic [31:0]         elapsed_i,
  input  logic [31:0]         divisor_i,
  output logic [31:0]         quot_o,
  output isl_pkg::div_stat_t  stat_o
);
  localparam int PW     = isl_pkg::PROD_W;
  localparam int STEP_W = $clog2(PW + 1);

  logic              busy_q, busy_d;
  logic              done_q, done_d;
  logic [STEP_W-1:0] step_q, step_d;
  logic [PW-1:0]     dq_q, dq_d;
  logic [31:0]       rem_q, rem_d;
  logic [31:0]       quot_q, quot_d;
  logic [32:0]       rem_sh;
  logic              ge;

  // One restoring step; divisor 0 yields all ones naturally
  assign rem_sh = {rem_q, dq_q[PW-1]};
  assign ge     = rem_sh >= {1'b0, divisor_i};

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    step_d = step_q;
    dq_d   = dq_q;
    rem_d  = rem_q;
    quot_d = quot_q;
    if (start_i) begin
      busy_d = 1'b1;
      step_d = STEP_W'(PW);
      dq_d   = PW'(elapsed_i) * PW'(isl_pkg::MICROS_PER_SEC);
      rem_d  = '0;
      quot_d = '0;
    end else if (busy_q) begin
      dq_d   = {dq_q[PW-2:0], 1'b0};
      rem_d  = ge ? 32'(rem_sh - {1'b0, divisor_i}) : rem_sh[31:0];
      quot_d = {quot_q[30:0], ge};
      step_d = STEP_W'(step_q - 1'b1);
      if (step_q == STEP_W'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      step_q <= step_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dq_q   <= dq_d;
    rem_q  <= rem_d;
    quot_q <= quot_d;
  end

  assign quot_o      = quot_q;
  assign stat_o.busy = busy_q;
  assign stat_o.done = done_q;

  `ASSERT_HOLDS(a_start_when_idle, start_i |-> !busy_q, "divider started while busy")
  `ASSERT_HOLDS(a_done_after_busy, $fell(busy_q) |-> done_q, "divider finished without done")
endmodule
